// ----- rtl/grc_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the grid ray caster.
// Used by grc_front, grc_back and grid_ray_caster_unit; depends on nothing else.
package grc_pkg;

    localparam int RAY_COUNT_DEF  = 30;
    localparam int MAP_DIM_DEF    = 64;
    localparam int MAX_STEPS_DEF  = 8;
    localparam int CELL_SHIFT_DEF = 6;

    localparam int ANG_W     = 13;
    localparam int FULL_TURN = 5760;
    localparam int QUARTER   = 1440;
    localparam int HALF_FOV  = 480;
    localparam int RAY_STEP  = 32;
    localparam int NEAR_ZERO = 65;
    localparam int NO_HIT    = 25600000;

    localparam int SIN_W = 17;   // table magnitude, 0 .. 65536
    localparam int CW    = 32;   // signed Q.8 coordinate width
    localparam int DW    = 36;   // signed Q.8 distance width before saturation
    localparam int MW    = 18;   // multiplier operand a
    localparam int MBW   = 34;   // multiplier operand b
    localparam int PW    = MW + MBW;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [2:0] CFG_PLAYER_X    = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y    = 3'd1;
    localparam logic [2:0] CFG_MAP_COLS    = 3'd2;
    localparam logic [2:0] CFG_MAP_ROWS    = 3'd3;
    localparam logic [2:0] CFG_VIEW_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_VIEW_HEIGHT = 3'd5;

    typedef struct packed {
        logic [19:0] player_x;
        logic [19:0] player_y;
        logic [6:0]  map_cols;
        logic [6:0]  map_rows;
        logic [11:0] view_width;
        logic [11:0] view_height;
    } t_cfg;

    typedef struct packed {
        logic             is_cast;
        logic             map_ok;
        logic [5:0]       cell_x;
        logic [5:0]       cell_y;
        logic             wall;
        logic [ANG_W-1:0] angle;
    } t_item;

    typedef struct packed {
        logic        neg;
        logic [10:0] idx;
    } t_quad;

    typedef logic [SIN_W-1:0] t_sine_tab [0:QUARTER];

    // Integer Taylor series in Q30, rounded to Q16.
    function automatic t_sine_tab sine_table();
        t_sine_tab          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 a;
        int                 k;
        for (a = 0; a <= QUARTER; a++) begin
            x    = (64'(a) * PI_Q30 + 64'd1440) / 64'd2880;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[a] = SIN_W'(($unsigned(sum) + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = sine_table();

    // Folds a full-turn angle onto the quarter-wave table.
    function automatic t_quad sine_quad(input logic [ANG_W-1:0] a);
        t_quad q;
        if (a < ANG_W'(QUARTER)) begin
            q.neg = 1'b0;
            q.idx = 11'(a);
        end else if (a < ANG_W'(2 * QUARTER)) begin
            q.neg = 1'b0;
            q.idx = 11'(ANG_W'(2 * QUARTER) - a);
        end else if (a < ANG_W'(3 * QUARTER)) begin
            q.neg = 1'b1;
            q.idx = 11'(a - ANG_W'(2 * QUARTER));
        end else begin
            q.neg = 1'b1;
            q.idx = 11'(ANG_W'(FULL_TURN) - a);
        end
        return q;
    endfunction

    function automatic logic [23:0] sat24(input logic signed [CW-1:0] v);
        if (v > $signed(CW'(24'sh7FFFFF))) begin
            return 24'h7FFFFF;
        end else if (v < -$signed(CW'(32'sh800000))) begin
            return 24'h800000;
        end
        return v[23:0];
    endfunction

    function automatic logic [25:0] sat26(input logic signed [DW-1:0] v);
        if (v > $signed(DW'(26'h1FFFFFF))) begin
            return 26'h1FFFFFF;
        end else if (v < -$signed(DW'(36'h2000000))) begin
            return 26'h2000000;
        end
        return v[25:0];
    endfunction

endpackage

// ----- rtl/grc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module grc_ram #(
    parameter int W     = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/grc_fifo.sv -----
// Short item queue between the front and back parts.
// Depends on nothing.
module grc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CNW-1:0] r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CNW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// ----- rtl/grc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module grc_div #(
    parameter int NW  = 33,
    parameter int DVW = 17
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_done,
    output logic [NW-1:0]  o_quot
);
    localparam int CNW = $clog2(NW + 1);

    logic [DVW:0]   r_rem;
    logic [NW-1:0]  r_q;
    logic [DVW-1:0] r_div;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW:0]   rem_sh;

    assign rem_sh = {r_rem[DVW-1:0], r_q[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_div}) begin
                r_rem <= rem_sh - {1'b0, r_div};
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- rtl/grc_front.sv -----
// Front part: takes input transfers, folds the heading and checks map-write bounds.
// Depends on grc_pkg.
module grc_front import grc_pkg::*; #(
    parameter int MAP_DIM = MAP_DIM_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_hold,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_mode,
    input  logic [5:0]       i_cell_x,
    input  logic [5:0]       i_cell_y,
    input  logic             i_wall,
    input  logic [ANG_W-1:0] i_view_angle,
    output logic             o_push,
    output t_item            o_item,
    input  logic             i_full
);
    logic             r_valid;
    t_item            r_item;
    t_item            item;
    logic [ANG_W-1:0] a1;
    logic [ANG_W-1:0] a2;

    always_comb begin
        a1 = (i_view_angle >= ANG_W'(FULL_TURN)) ? i_view_angle - ANG_W'(FULL_TURN)
                                                  : i_view_angle;
        a2 = a1 + ANG_W'(HALF_FOV);
        if (a2 >= ANG_W'(FULL_TURN)) begin
            a2 = a2 - ANG_W'(FULL_TURN);
        end
        item.is_cast = i_mode;
        item.map_ok  = (9'(i_cell_x) < 9'(MAP_DIM)) && (9'(i_cell_y) < 9'(MAP_DIM));
        item.cell_x  = i_cell_x;
        item.cell_y  = i_cell_y;
        item.wall    = i_wall;
        item.angle   = a2;
    end

    assign o_ready = !i_hold && (!r_valid || !i_full);
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end else if (!i_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= item;
        end
    end
endmodule

// ----- rtl/grc_back.sv -----
// Back part: map clearing and writes, and the per-ray sequencer with its walk.
// Depends on grc_pkg, grc_ram and grc_div.
module grc_back import grc_pkg::*; #(
    parameter int RAY_COUNT  = RAY_COUNT_DEF,
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_ray_index,
    output logic [23:0] o_hit_x,
    output logic [23:0] o_hit_y,
    output logic [25:0] o_distance,
    output logic        o_vertical_side,
    output logic        o_last
);
    localparam int QSH    = 8 + CELL_SHIFT;
    localparam int MAP_AW = $clog2(MAP_DIM * MAP_DIM);
    localparam int RAYW   = $clog2(RAY_COUNT + 1);
    localparam int STEPW  = $clog2(MAX_STEPS + 1);
    localparam int QNW    = SIN_W + 16;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SIN   = 4'd2;
    localparam logic [3:0] ST_COS   = 4'd3;
    localparam logic [3:0] ST_COSW  = 4'd4;
    localparam logic [3:0] ST_PSET  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_MQ    = 4'd7;
    localparam logic [3:0] ST_WCHK  = 4'd8;
    localparam logic [3:0] ST_WRD   = 4'd9;
    localparam logic [3:0] ST_WMOV  = 4'd10;
    localparam logic [3:0] ST_D1    = 4'd11;
    localparam logic [3:0] ST_D2    = 4'd12;
    localparam logic [3:0] ST_D3    = 4'd13;
    localparam logic [3:0] ST_PEND  = 4'd14;
    localparam logic [3:0] ST_EMIT  = 4'd15;

    localparam logic signed [CW-1:0] CELL = CW'(1) <<< QSH;

    logic [3:0]              r_state;
    logic [MAP_AW-1:0]       r_clr_addr;
    logic [ANG_W-1:0]        r_angle;
    logic [RAYW-1:0]         r_ray;
    logic [SIN_W-1:0]        r_rom;
    logic                    r_rom_neg;
    logic signed [MW-1:0]    r_s;
    logic signed [MW-1:0]    r_c;
    logic                    r_pass;
    logic                    r_tneg;
    logic                    r_fwd;
    logic signed [CW-1:0]    r_p0;
    logic signed [MBW-1:0]   r_t;
    logic signed [CW-1:0]    r_wx;
    logic signed [CW-1:0]    r_wy;
    logic signed [CW-1:0]    r_wox;
    logic signed [CW-1:0]    r_woy;
    logic [STEPW-1:0]        r_steps;
    logic signed [PW-1:0]    r_prod;
    logic signed [PW-1:0]    r_acc;
    logic signed [DW-1:0]    r_dist;
    logic signed [CW-1:0]    r_vx;
    logic signed [CW-1:0]    r_vy;
    logic signed [DW-1:0]    r_dv;
    logic                    r_out_valid;
    logic [5:0]              r_o_idx;
    logic [23:0]             r_o_x;
    logic [23:0]             r_o_y;
    logic [25:0]             r_o_d;
    logic                    r_o_side;
    logic                    r_o_last;

    logic [ANG_W-1:0]        cos_angle;
    t_quad                   quad;
    logic signed [MW-1:0]    rom_val;
    logic signed [MW-1:0]    num;
    logic signed [MW-1:0]    den;
    logic [MW-1:0]           num_mag;
    logic [MW-1:0]           den_mag;
    logic                    walks;
    logic                    fwd;
    logic signed [CW-1:0]    px;
    logic signed [CW-1:0]    py;
    logic signed [CW-1:0]    pp;
    logic signed [CW-1:0]    pq;
    logic signed [CW-1:0]    base;
    logic                    div_start;
    logic                    div_done;
    logic [QNW-1:0]          div_q;
    logic signed [MBW-1:0]   t_now;
    logic signed [MW-1:0]    mul_a;
    logic signed [MBW-1:0]   mul_b;
    logic signed [PW-1:0]    t_wide;
    logic signed [CW-1:0]    q0;
    logic signed [CW-1:0]    oq;
    logic signed [CW-1:0]    cx;
    logic signed [CW-1:0]    cy;
    logic [8:0]              cols;
    logic [8:0]              rows;
    logic                    in_map;
    logic signed [CW-1:0]    nx;
    logic signed [CW-1:0]    ny;
    logic                    off_box;
    logic                    ram_we;
    logic [MAP_AW-1:0]       ram_waddr;
    logic                    ram_wdata;
    logic [MAP_AW-1:0]       ram_raddr;
    logic                    ram_rdata;
    logic                    out_free;
    logic                    vnear;

    assign px = $signed(CW'(i_cfg.player_x));
    assign py = $signed(CW'(i_cfg.player_y));

    // Sine table lookup, one read a cycle.
    always_comb begin
        cos_angle = r_angle + ANG_W'(QUARTER);
        if (cos_angle >= ANG_W'(FULL_TURN)) begin
            cos_angle = cos_angle - ANG_W'(FULL_TURN);
        end
        quad = sine_quad((r_state == ST_SIN) ? r_angle : cos_angle);
        rom_val = r_rom_neg ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});
    end

    always_ff @(posedge i_clk) begin
        r_rom     <= SINE_TAB[quad.idx];
        r_rom_neg <= quad.neg;
    end

    // Pass setup: the vertical pass divides sin by cos, the horizontal one cos by sin.
    always_comb begin
        num     = r_pass ? r_c : r_s;
        den     = r_pass ? r_s : r_c;
        num_mag = num[MW-1] ? MW'(-num) : MW'(num);
        den_mag = den[MW-1] ? MW'(-den) : MW'(den);
        walks   = (den > $signed(MW'(NEAR_ZERO))) || (den < -$signed(MW'(NEAR_ZERO)));
        fwd     = r_pass ? r_s[MW-1] : (r_c > 0);
        pp      = r_pass ? py : px;
        pq      = r_pass ? px : py;
        base    = (pp >>> QSH) <<< QSH;
        t_now   = r_tneg ? -$signed(MBW'(div_q)) : $signed(MBW'(div_q));
    end

    assign div_start = (r_state == ST_PSET) && walks;

    grc_div #(
        .NW (QNW),
        .DVW(SIN_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend({num_mag[SIN_W-1:0], 16'b0}),
        .i_divisor (den_mag[SIN_W-1:0]),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    // Shared multiplier, registered.
    always_comb begin
        case (r_state)
            ST_D1: begin
                mul_a = r_c;
                mul_b = MBW'(r_wx) - MBW'(px);
            end
            ST_D2: begin
                mul_a = r_s;
                mul_b = MBW'(r_wy) - MBW'(py);
            end
            default: begin
                mul_a = MW'(pp - r_p0);
                mul_b = t_now;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
    end

    // First crossing along the secondary axis, and its per-step offset.
    always_comb begin
        t_wide = PW'(r_t) <<< QSH;
        q0 = CW'(r_prod >>> 16) + pq;
        oq = r_fwd ? CW'((-t_wide) >>> 16) : CW'(t_wide >>> 16);
    end

    // Map cell of the walk point and the next step.
    always_comb begin
        cx     = r_wx >>> QSH;
        cy     = r_wy >>> QSH;
        cols   = (9'(i_cfg.map_cols) < 9'(MAP_DIM)) ? 9'(i_cfg.map_cols) : 9'(MAP_DIM);
        rows   = (9'(i_cfg.map_rows) < 9'(MAP_DIM)) ? 9'(i_cfg.map_rows) : 9'(MAP_DIM);
        in_map = !cx[CW-1] && !cy[CW-1] && (cx < $signed(CW'(cols))) &&
                 (cy < $signed(CW'(rows)));
        nx      = r_wx + r_wox;
        ny      = r_wy + r_woy;
        off_box = nx[CW-1] || ny[CW-1] ||
                  (nx > $signed(CW'({i_cfg.view_width, 8'b0}))) ||
                  (ny > $signed(CW'({i_cfg.view_height, 8'b0})));
        ram_raddr = cy[MAP_AW-1:0] * MAP_AW'(MAP_DIM) + cx[MAP_AW-1:0];
    end

    assign o_pop      = (r_state == ST_IDLE) && i_item_valid;
    assign o_clearing = (r_state == ST_CLEAR);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = o_pop && !i_item.is_cast && i_item.map_ok;
            ram_waddr = MAP_AW'(i_item.cell_y) * MAP_AW'(MAP_DIM) + MAP_AW'(i_item.cell_x);
            ram_wdata = i_item.wall;
        end
    end

    grc_ram #(
        .W    (1),
        .DEPTH(MAP_DIM * MAP_DIM)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign out_free = !r_out_valid || i_ready;
    assign vnear    = r_dv < r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_ray       <= '0;
            r_pass      <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == MAP_AW'(MAP_DIM * MAP_DIM - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_item_valid && i_item.is_cast) begin
                        r_angle <= i_item.angle;
                        r_ray   <= '0;
                        r_pass  <= 1'b0;
                        r_state <= ST_SIN;
                    end
                end
                ST_SIN: begin
                    r_state <= ST_COS;
                end
                ST_COS: begin
                    r_s     <= rom_val;
                    r_state <= ST_COSW;
                end
                ST_COSW: begin
                    r_c     <= rom_val;
                    r_state <= ST_PSET;
                end
                ST_PSET: begin
                    if (walks) begin
                        r_tneg  <= num[MW-1] ^ den[MW-1];
                        r_fwd   <= fwd;
                        r_p0    <= fwd ? base + CELL : base - CW'(1);
                        r_state <= ST_DIV;
                    end else begin
                        r_wx    <= px;
                        r_wy    <= py;
                        r_dist  <= DW'(NO_HIT);
                        r_state <= ST_PEND;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_t     <= t_now;
                        r_state <= ST_MQ;
                    end
                end
                ST_MQ: begin
                    if (r_pass) begin
                        r_wy  <= r_p0;
                        r_wx  <= q0;
                        r_woy <= r_fwd ? CELL : -CELL;
                        r_wox <= oq;
                    end else begin
                        r_wx  <= r_p0;
                        r_wy  <= q0;
                        r_wox <= r_fwd ? CELL : -CELL;
                        r_woy <= oq;
                    end
                    r_steps <= '0;
                    r_state <= ST_WCHK;
                end
                ST_WCHK: begin
                    r_state <= in_map ? ST_WRD : ST_WMOV;
                end
                ST_WRD: begin
                    r_state <= ram_rdata ? ST_D1 : ST_WMOV;
                end
                ST_WMOV: begin
                    r_wx    <= nx;
                    r_wy    <= ny;
                    r_steps <= r_steps + 1'b1;
                    if (off_box || (r_steps == STEPW'(MAX_STEPS - 1))) begin
                        r_dist  <= DW'(NO_HIT);
                        r_state <= ST_PEND;
                    end else begin
                        r_state <= ST_WCHK;
                    end
                end
                ST_D1: begin
                    r_state <= ST_D2;
                end
                ST_D2: begin
                    r_acc   <= r_prod;
                    r_state <= ST_D3;
                end
                ST_D3: begin
                    r_dist  <= DW'((r_acc - r_prod) >>> 16);
                    r_state <= ST_PEND;
                end
                ST_PEND: begin
                    if (!r_pass) begin
                        r_vx    <= r_wx;
                        r_vy    <= r_wy;
                        r_dv    <= r_dist;
                        r_pass  <= 1'b1;
                        r_state <= ST_PSET;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_idx     <= 6'(r_ray);
                        r_o_x       <= sat24(vnear ? r_vx : r_wx);
                        r_o_y       <= sat24(vnear ? r_vy : r_wy);
                        r_o_d       <= sat26(vnear ? r_dv : r_dist);
                        r_o_side    <= vnear;
                        r_o_last    <= (r_ray == RAYW'(RAY_COUNT - 1));
                        r_angle     <= (r_angle < ANG_W'(RAY_STEP))
                                       ? r_angle + ANG_W'(FULL_TURN - RAY_STEP)
                                       : r_angle - ANG_W'(RAY_STEP);
                        r_ray       <= r_ray + 1'b1;
                        r_pass      <= 1'b0;
                        r_state     <= (r_ray == RAYW'(RAY_COUNT - 1)) ? ST_IDLE : ST_SIN;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_ray_index     = r_o_idx;
    assign o_hit_x         = r_o_x;
    assign o_hit_y         = r_o_y;
    assign o_distance      = r_o_d;
    assign o_vertical_side = r_o_side;
    assign o_last          = r_o_last;
endmodule

// ----- rtl/grid_ray_caster_unit.sv -----
// Top level of the grid ray caster: configuration registers, front part, queue, back part.
// Depends on grc_pkg, grc_front, grc_fifo and grc_back.

// The block keeps a MAP_DIM x MAP_DIM wall map and casts a frame of RAY_COUNT rays for
// each cast transfer (tuser = 1); a map transfer (tuser = 0) writes one cell and gives no
// result. After reset the map is cleared, one cell at a time, and during the clearing no
// input transfer is taken; configuration writes are taken at any time and are meant to
// be made while the block is idle. Each ray reads the table for its sine and cosine, then
// for each of its two passes does one divider run plus setup, a walk of up to MAX_STEPS
// grid steps (at most one wall-map read each) and, on a hit, the distance product. The
// serial divider and the single wall-map read port bound the time a ray takes. Results
// leave through an output register, so the next ray is worked on while one waits to be
// taken, and a short queue lets new items be taken while a frame is still being cast.
module grid_ray_caster_unit import grc_pkg::*; #(
    parameter int RAY_COUNT  = RAY_COUNT_DEF,
    parameter int MAP_DIM    = MAP_DIM_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_x [5:0], cell_y [11:6], wall [12], view_angle [25:13], zero [31:26]
    input  logic [31:0] s_axis_tdata,
    // mode [0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ray_index [5:0], hit_x [29:6], hit_y [53:30], distance [79:54]
    output logic [79:0] m_axis_tdata,
    // vertical_side [0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    t_cfg  r_cfg;
    logic  clearing;
    logic  push;
    t_item front_item;
    logic  fifo_full;
    logic  fifo_valid;
    t_item fifo_item;
    logic  pop;

    // Configuration registers; a write to an index past the list is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.player_x    <= '0;
            r_cfg.player_y    <= '0;
            r_cfg.map_cols    <= 7'd64;
            r_cfg.map_rows    <= 7'd64;
            r_cfg.view_width  <= 12'd1024;
            r_cfg.view_height <= 12'd512;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PLAYER_X:    r_cfg.player_x    <= i_cfg_data;
                CFG_PLAYER_Y:    r_cfg.player_y    <= i_cfg_data;
                CFG_MAP_COLS:    r_cfg.map_cols    <= i_cfg_data[6:0];
                CFG_MAP_ROWS:    r_cfg.map_rows    <= i_cfg_data[6:0];
                CFG_VIEW_WIDTH:  r_cfg.view_width  <= i_cfg_data[11:0];
                CFG_VIEW_HEIGHT: r_cfg.view_height <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    grc_front #(
        .MAP_DIM(MAP_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser[0]),
        .i_cell_x    (s_axis_tdata[5:0]),
        .i_cell_y    (s_axis_tdata[11:6]),
        .i_wall      (s_axis_tdata[12]),
        .i_view_angle(s_axis_tdata[25:13]),
        .o_push      (push),
        .o_item      (front_item),
        .i_full      (fifo_full)
    );

    grc_fifo #(
        .W    ($bits(t_item)),
        .DEPTH(2)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_item),
        .o_full (fifo_full),
        .i_pop  (pop),
        .o_valid(fifo_valid),
        .o_data (fifo_item)
    );

    grc_back #(
        .RAY_COUNT (RAY_COUNT),
        .MAP_DIM   (MAP_DIM),
        .MAX_STEPS (MAX_STEPS),
        .CELL_SHIFT(CELL_SHIFT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item_valid   (fifo_valid),
        .i_item         (fifo_item),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_ray_index    (m_axis_tdata[5:0]),
        .o_hit_x        (m_axis_tdata[29:6]),
        .o_hit_y        (m_axis_tdata[53:30]),
        .o_distance     (m_axis_tdata[79:54]),
        .o_vertical_side(m_axis_tuser[0]),
        .o_last         (m_axis_tlast)
    );
endmodule
